// ===== hw/rtl/damped_oscillator_ode_stepper_core_assert.svh =====
// assertion macros for the ode stepper
`ifndef DAMPED_OSCILLATOR_ODE_STEPPER_CORE_ASSERT_SVH
`define DAMPED_OSCILLATOR_ODE_STEPPER_CORE_ASSERT_SVH

// same-cycle implication
`define DOSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DOSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dosc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dosc_pkg;

   localparam int VW     = 48;
   localparam int FW     = 24;
   localparam int HW     = 25;
   localparam int DIGW   = 5;
   localparam int NDIG   = (HW + DIGW - 1) / DIGW;
   localparam int HPADW  = NDIG * DIGW;
   localparam int PW     = VW + HPADW + 1;
   localparam int CNTW   = $clog2(NDIG + 1);
   localparam int IDXW   = 16;
   localparam int UPCW   = 6;
   localparam int CSRW   = 2;

   localparam logic [CSRW-1:0] CSR_STEP_SIZE  = 2'd0;
   localparam logic [CSRW-1:0] CSR_METHOD     = 2'd1;
   localparam logic [CSRW-1:0] CSR_NUM_POINTS = 2'd2;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;
   localparam logic METHOD_RK2  = 1'b0;
   localparam logic METHOD_ABM2 = 1'b1;

   localparam logic [HW-1:0]   STEP_RESET   = 25'd1677722;
   localparam logic [IDXW-1:0] POINTS_RESET = 16'd11;
   localparam logic [UPCW-1:0] ABM_START    = 6'd17;

   typedef logic signed [VW-1:0] val_type;

   localparam val_type VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam val_type VMIN = {1'b1, {(VW-1){1'b0}}};

   typedef struct packed {
      logic    req_type;
      val_type start_position;
      val_type start_velocity;
   } req_type_type;

   typedef struct packed {
      val_type         position;
      val_type         velocity;
      logic [IDXW-1:0] point_index;
      logic            last_point;
      logic            saturated;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic half_step;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic sat;
   } mul_rsp_type;

   typedef struct packed {
      logic    sat;
      val_type val;
   } alu_res_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_NEG, OP_MUL25, OP_MUL3, OP_HALF, OP_MULH, OP_MULH2, OP_COMMIT
   } op_type;

   typedef enum logic [3:0] {
      R_P, R_V, R_PP, R_PV, R_T1, R_T2, R_T3, R_T4, R_T5
   } reg_sel_type;

   typedef struct packed {
      op_type      op;
      reg_sel_type a;
      reg_sel_type b;
      reg_sel_type d;
   } uinstr_type;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_MWAIT, ST_DONE} state_type;
   typedef enum logic [1:0] {M_IDLE, M_RUN, M_ROUND, M_FIN} mul_state_type;

   function automatic alu_res_type s_add(input val_type a, input val_type b);
      logic signed [VW:0] s;
      alu_res_type        r;
      s = {a[VW-1], a} + {b[VW-1], b};
      r.sat = s[VW] != s[VW-1];
      r.val = r.sat ? (s[VW] ? VMIN : VMAX) : s[VW-1:0];
      return r;
   endfunction

   function automatic alu_res_type s_neg(input val_type a);
      alu_res_type r;
      r.sat = a == VMIN;
      r.val = r.sat ? VMAX : -a;
      return r;
   endfunction

   function automatic alu_res_type s_mul25(input val_type a);
      logic signed [VW+5:0] e;
      logic signed [VW+5:0] m;
      alu_res_type          r;
      e = {{6{a[VW-1]}}, a};
      m = (e <<< 4) + (e <<< 3) + e;
      r.sat = (m[VW+5:VW-1] != '0) && (m[VW+5:VW-1] != '1);
      r.val = r.sat ? (m[VW+5] ? VMIN : VMAX) : m[VW-1:0];
      return r;
   endfunction

   function automatic alu_res_type s_mul3(input val_type a);
      logic signed [VW+1:0] e;
      logic signed [VW+1:0] m;
      alu_res_type          r;
      e = {{2{a[VW-1]}}, a};
      m = (e <<< 1) + e;
      r.sat = (m[VW+1:VW-1] != '0) && (m[VW+1:VW-1] != '1);
      r.val = r.sat ? (m[VW+1] ? VMIN : VMAX) : m[VW-1:0];
      return r;
   endfunction

   function automatic alu_res_type s_half(input val_type a, input val_type b);
      logic signed [VW:0] s;
      alu_res_type        r;
      s = {a[VW-1], a} + {b[VW-1], b} + (VW+1)'(1);
      r.sat = 1'b0;
      r.val = s[VW:1];
      return r;
   endfunction

   function automatic uinstr_type ui(input op_type op, input reg_sel_type a,
                                     input reg_sel_type b, input reg_sel_type d);
      uinstr_type u;
      u.op = op;
      u.a  = a;
      u.b  = b;
      u.d  = d;
      return u;
   endfunction

   // rk2 at 0, abm2 from ABM_START
   function automatic uinstr_type ucode(input logic [UPCW-1:0] upc);
      uinstr_type u;
      unique case (upc)
         6'd0:  u = ui(OP_MULH,   R_V,  R_T1, R_T1);
         6'd1:  u = ui(OP_MUL25,  R_V,  R_T1, R_T2);
         6'd2:  u = ui(OP_ADD,    R_T2, R_P,  R_T2);
         6'd3:  u = ui(OP_NEG,    R_T2, R_T1, R_T2);
         6'd4:  u = ui(OP_MULH,   R_T2, R_T1, R_T2);
         6'd5:  u = ui(OP_ADD,    R_P,  R_T1, R_T3);
         6'd6:  u = ui(OP_ADD,    R_V,  R_T2, R_T4);
         6'd7:  u = ui(OP_MULH,   R_T4, R_T1, R_T5);
         6'd8:  u = ui(OP_MUL25,  R_T4, R_T1, R_T4);
         6'd9:  u = ui(OP_ADD,    R_T4, R_T3, R_T4);
         6'd10: u = ui(OP_NEG,    R_T4, R_T1, R_T4);
         6'd11: u = ui(OP_MULH,   R_T4, R_T1, R_T4);
         6'd12: u = ui(OP_HALF,   R_T1, R_T5, R_T1);
         6'd13: u = ui(OP_ADD,    R_P,  R_T1, R_T1);
         6'd14: u = ui(OP_HALF,   R_T2, R_T4, R_T2);
         6'd15: u = ui(OP_ADD,    R_V,  R_T2, R_T2);
         6'd16: u = ui(OP_COMMIT, R_T1, R_T1, R_T1);
         6'd17: u = ui(OP_MUL25,  R_V,  R_T1, R_T2);
         6'd18: u = ui(OP_ADD,    R_T2, R_P,  R_T2);
         6'd19: u = ui(OP_NEG,    R_T2, R_T1, R_T2);
         6'd20: u = ui(OP_MUL25,  R_PV, R_T1, R_T3);
         6'd21: u = ui(OP_ADD,    R_T3, R_PP, R_T3);
         6'd22: u = ui(OP_NEG,    R_T3, R_T1, R_T3);
         6'd23: u = ui(OP_MUL3,   R_V,  R_T1, R_T4);
         6'd24: u = ui(OP_NEG,    R_PV, R_T1, R_T5);
         6'd25: u = ui(OP_ADD,    R_T4, R_T5, R_T4);
         6'd26: u = ui(OP_MULH2,  R_T4, R_T1, R_T4);
         6'd27: u = ui(OP_ADD,    R_P,  R_T4, R_T4);
         6'd28: u = ui(OP_MUL3,   R_T2, R_T1, R_T5);
         6'd29: u = ui(OP_NEG,    R_T3, R_T1, R_T3);
         6'd30: u = ui(OP_ADD,    R_T5, R_T3, R_T5);
         6'd31: u = ui(OP_MULH2,  R_T5, R_T1, R_T5);
         6'd32: u = ui(OP_ADD,    R_V,  R_T5, R_T5);
         6'd33: u = ui(OP_ADD,    R_V,  R_T5, R_T1);
         6'd34: u = ui(OP_MULH2,  R_T1, R_T1, R_T1);
         6'd35: u = ui(OP_ADD,    R_P,  R_T1, R_T1);
         6'd36: u = ui(OP_MUL25,  R_T5, R_T1, R_T3);
         6'd37: u = ui(OP_ADD,    R_T3, R_T4, R_T3);
         6'd38: u = ui(OP_NEG,    R_T3, R_T1, R_T3);
         6'd39: u = ui(OP_ADD,    R_T2, R_T3, R_T3);
         6'd40: u = ui(OP_MULH2,  R_T3, R_T1, R_T3);
         6'd41: u = ui(OP_ADD,    R_V,  R_T3, R_T2);
         default: u = ui(OP_COMMIT, R_T1, R_T1, R_T1);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dosc_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dosc_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dosc_pkg::mul_req_type ctl,
   input  wire dosc_pkg::val_type     operand,
   input  wire logic [dosc_pkg::HW-1:0] step,
   output dosc_pkg::mul_rsp_type      sts,
   output dosc_pkg::val_type          result
);

   dosc_pkg::mul_state_type state_ff, state_in;
   logic                          neg_ff, neg_in;
   logic                          half_ff, half_in;
   logic [dosc_pkg::VW-1:0]       mag_ff, mag_in;
   logic [dosc_pkg::HPADW-1:0]    h_ff, h_in;
   logic [dosc_pkg::CNTW-1:0]     cnt_ff, cnt_in;
   logic [dosc_pkg::PW-1:0]       acc_ff, acc_in;
   logic [dosc_pkg::PW-1:0]       quo;
   logic [dosc_pkg::PW-1:0]       lim;
   logic [dosc_pkg::VW-1:0]       qclip;
   logic                          over;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dosc_pkg::M_IDLE:  if (ctl.start) state_in = dosc_pkg::M_RUN;
         dosc_pkg::M_RUN:
            if (cnt_ff == dosc_pkg::CNTW'(dosc_pkg::NDIG - 1)) state_in = dosc_pkg::M_ROUND;
         dosc_pkg::M_ROUND: state_in = dosc_pkg::M_FIN;
         dosc_pkg::M_FIN:   state_in = dosc_pkg::M_IDLE;
         default:           state_in = dosc_pkg::M_IDLE;
      endcase
   end

   always_comb begin
      neg_in  = neg_ff;
      half_in = half_ff;
      mag_in  = mag_ff;
      h_in    = h_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      unique case (state_ff)
         dosc_pkg::M_IDLE: begin
            neg_in  = operand[dosc_pkg::VW-1];
            half_in = ctl.half_step;
            mag_in  = operand[dosc_pkg::VW-1] ? dosc_pkg::VW'(-operand) : operand;
            h_in    = dosc_pkg::HPADW'(step) << (dosc_pkg::HPADW - dosc_pkg::HW);
            cnt_in  = '0;
            acc_in  = '0;
         end
         dosc_pkg::M_RUN: begin
            // one digit of h per cycle, msb first
            acc_in = (acc_ff << dosc_pkg::DIGW)
                   + (dosc_pkg::PW'(mag_ff)
                      * dosc_pkg::PW'(h_ff[dosc_pkg::HPADW-1 -: dosc_pkg::DIGW]));
            h_in   = h_ff << dosc_pkg::DIGW;
            cnt_in = cnt_ff + 1'b1;
         end
         dosc_pkg::M_ROUND: begin
            acc_in = acc_ff + (half_ff ? (dosc_pkg::PW'(1) << dosc_pkg::FW)
                                       : (dosc_pkg::PW'(1) << (dosc_pkg::FW - 1)));
         end
         default: ;
      endcase
   end

   always_comb begin
      quo   = half_ff ? (acc_ff >> (dosc_pkg::FW + 1)) : (acc_ff >> dosc_pkg::FW);
      lim   = neg_ff ? (dosc_pkg::PW'(1) << (dosc_pkg::VW - 1))
                     : dosc_pkg::PW'(dosc_pkg::VMAX);
      over  = quo > lim;
      qclip = over ? lim[dosc_pkg::VW-1:0] : quo[dosc_pkg::VW-1:0];
      result   = neg_ff ? -dosc_pkg::val_type'(qclip) : dosc_pkg::val_type'(qclip);
      sts.done = state_ff == dosc_pkg::M_FIN;
      sts.sat  = over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dosc_pkg::M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff  <= neg_in;
      half_ff <= half_in;
      mag_ff  <= mag_in;
      h_ff    <= h_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/damped_oscillator_ode_stepper_core.sv =====
// load, and advance at the last point, go straight to the response state;
// rk2 and abm2 advances run their microcode first
// throughput: one transaction at a time, set by the shared digit-serial
// h multiplier (5 digits plus round and finish per product, 4 products a step)
// reset: synchronous; state, point count, rsp valid and p/v clear; CSRs take defaults
`timescale 1ns / 1ps
`default_nettype none
module damped_oscillator_ode_stepper_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire dosc_pkg::req_type_type       req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output dosc_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [dosc_pkg::CSRW-1:0]    csr_index,
   input  wire logic [dosc_pkg::HW-1:0]      csr_wdata
);

   dosc_pkg::state_type       state_ff, state_in;
   logic [dosc_pkg::HW-1:0]   step_ff;
   logic                      method_ff;
   logic [dosc_pkg::IDXW-1:0] npts_ff;
   logic [dosc_pkg::IDXW-1:0] count_ff;
   logic [dosc_pkg::IDXW-1:0] last_idx;
   logic [dosc_pkg::UPCW-1:0] upc_ff;
   logic                      sat_ff;
   dosc_pkg::val_type         p_ff, v_ff, pp_ff, pv_ff;
   dosc_pkg::val_type         t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   dosc_pkg::rsp_type         rsp_ff;
   logic                      rsp_valid_ff;

   dosc_pkg::uinstr_type      ins;
   dosc_pkg::val_type         opa, opb, wr_val;
   dosc_pkg::alu_res_type     alu;
   dosc_pkg::mul_req_type     mreq;
   dosc_pkg::mul_rsp_type     mrsp;
   dosc_pkg::val_type         mres;
   logic                      accept, is_mul, alu_wr, mul_wr, commit, rsp_load, wr_en;
   logic                      wr_sat, can_step;

   function automatic dosc_pkg::val_type pick(input dosc_pkg::reg_sel_type s,
      input dosc_pkg::val_type p, input dosc_pkg::val_type v,
      input dosc_pkg::val_type pp, input dosc_pkg::val_type pv,
      input dosc_pkg::val_type t1, input dosc_pkg::val_type t2,
      input dosc_pkg::val_type t3, input dosc_pkg::val_type t4,
      input dosc_pkg::val_type t5);
      dosc_pkg::val_type r;
      unique case (s)
         dosc_pkg::R_P:  r = p;
         dosc_pkg::R_V:  r = v;
         dosc_pkg::R_PP: r = pp;
         dosc_pkg::R_PV: r = pv;
         dosc_pkg::R_T1: r = t1;
         dosc_pkg::R_T2: r = t2;
         dosc_pkg::R_T3: r = t3;
         dosc_pkg::R_T4: r = t4;
         dosc_pkg::R_T5: r = t5;
         default:        r = t1;
      endcase
      return r;
   endfunction

   assign last_idx = (npts_ff == '0) ? '0 : npts_ff - 1'b1;
   assign can_step = count_ff < last_idx;
   assign ins      = dosc_pkg::ucode(upc_ff);
   assign is_mul   = (ins.op == dosc_pkg::OP_MULH) || (ins.op == dosc_pkg::OP_MULH2);
   assign opa = pick(ins.a, p_ff, v_ff, pp_ff, pv_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff);
   assign opb = pick(ins.b, p_ff, v_ff, pp_ff, pv_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff);

   always_comb begin
      unique case (ins.op)
         dosc_pkg::OP_ADD:   alu = dosc_pkg::s_add(opa, opb);
         dosc_pkg::OP_NEG:   alu = dosc_pkg::s_neg(opa);
         dosc_pkg::OP_MUL25: alu = dosc_pkg::s_mul25(opa);
         dosc_pkg::OP_MUL3:  alu = dosc_pkg::s_mul3(opa);
         dosc_pkg::OP_HALF:  alu = dosc_pkg::s_half(opa, opb);
         default:            alu = '{sat: 1'b0, val: opa};
      endcase
   end

   dosc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mreq),
      .operand (opa),
      .step    (step_ff),
      .sts     (mrsp),
      .result  (mres)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dosc_pkg::ST_IDLE:
            if (req_valid) begin
               if (req_data.req_type == dosc_pkg::REQ_ADVANCE && can_step)
                  state_in = dosc_pkg::ST_EXEC;
               else
                  state_in = dosc_pkg::ST_DONE;
            end
         dosc_pkg::ST_EXEC:
            if (is_mul) state_in = dosc_pkg::ST_MWAIT;
            else if (ins.op == dosc_pkg::OP_COMMIT) state_in = dosc_pkg::ST_DONE;
         dosc_pkg::ST_MWAIT:
            if (mrsp.done) state_in = dosc_pkg::ST_EXEC;
         dosc_pkg::ST_DONE:
            if (!rsp_valid_ff || rsp_ready) state_in = dosc_pkg::ST_IDLE;
         default: state_in = dosc_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready      = state_ff == dosc_pkg::ST_IDLE;
      accept         = req_ready && req_valid;
      mreq.start     = (state_ff == dosc_pkg::ST_EXEC) && is_mul;
      mreq.half_step = ins.op == dosc_pkg::OP_MULH2;
      alu_wr   = (state_ff == dosc_pkg::ST_EXEC) && !is_mul
               && (ins.op != dosc_pkg::OP_COMMIT);
      mul_wr   = (state_ff == dosc_pkg::ST_MWAIT) && mrsp.done;
      commit   = (state_ff == dosc_pkg::ST_EXEC) && (ins.op == dosc_pkg::OP_COMMIT);
      rsp_load = (state_ff == dosc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      wr_en    = alu_wr || mul_wr;
      wr_val   = mul_wr ? mres : alu.val;
      wr_sat   = mul_wr ? mrsp.sat : alu.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dosc_pkg::ST_IDLE;
         step_ff      <= dosc_pkg::STEP_RESET;
         method_ff    <= dosc_pkg::METHOD_RK2;
         npts_ff      <= dosc_pkg::POINTS_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= '0;
         v_ff         <= '0;
         pp_ff        <= '0;
         pv_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               dosc_pkg::CSR_STEP_SIZE:  step_ff   <= csr_wdata;
               dosc_pkg::CSR_METHOD:     method_ff <= csr_wdata[0];
               dosc_pkg::CSR_NUM_POINTS: npts_ff   <= csr_wdata[dosc_pkg::IDXW-1:0];
               default: ;
            endcase
         end
         if (accept && req_data.req_type == dosc_pkg::REQ_LOAD) begin
            p_ff     <= req_data.start_position;
            pp_ff    <= req_data.start_position;
            v_ff     <= req_data.start_velocity;
            pv_ff    <= req_data.start_velocity;
            count_ff <= '0;
         end
         if (commit) begin
            pp_ff    <= p_ff;
            pv_ff    <= v_ff;
            p_ff     <= t1_ff;
            v_ff     <= t2_ff;
            count_ff <= count_ff + 1'b1;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         sat_ff <= 1'b0;
         upc_ff <= (method_ff == dosc_pkg::METHOD_ABM2 && count_ff != '0)
                   ? dosc_pkg::ABM_START : '0;
      end else if (wr_en) begin
         sat_ff <= sat_ff | wr_sat;
         upc_ff <= upc_ff + 1'b1;
      end
      if (wr_en) begin
         unique case (ins.d)
            dosc_pkg::R_T1: t1_ff <= wr_val;
            dosc_pkg::R_T2: t2_ff <= wr_val;
            dosc_pkg::R_T3: t3_ff <= wr_val;
            dosc_pkg::R_T4: t4_ff <= wr_val;
            dosc_pkg::R_T5: t5_ff <= wr_val;
            default: ;
         endcase
      end
      if (rsp_load) begin
         rsp_ff.position    <= p_ff;
         rsp_ff.velocity    <= v_ff;
         rsp_ff.point_index <= count_ff;
         rsp_ff.last_point  <= count_ff == last_idx;
         rsp_ff.saturated   <= sat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dosc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "damped_oscillator_ode_stepper_core_assert.svh"
module dosc_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire dosc_pkg::req_type_type    req_data,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire dosc_pkg::rsp_type         rsp_data,
   input wire logic                      csr_we,
   input wire logic [dosc_pkg::CSRW-1:0] csr_index,
   input wire logic [dosc_pkg::HW-1:0]   csr_wdata
);

   // start point never reports clipping
   `DOSC_ASSERT_IMPL(a_start_clean, clock, reset, rsp_valid && rsp_data.point_index == '0, !rsp_data.saturated, "point zero flagged saturated")
   // one transaction in flight
   `DOSC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready held after accept")
   // stalled result holds
   `DOSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind damped_oscillator_ode_stepper_core dosc_checker u_dosc_checker (.*);
`default_nettype wire
